/* hdl/mmp2_pkg.sv */
// Shared types and constants for the 2x2 modular matrix power unit.
// Holds the prime modulus, the Barrett reduction constant and the matrix type.
// No dependencies.
`default_nettype none

package mmp2_pkg;

    localparam int ELEM_W  = 30;
    localparam int POWER_W = 63;

    typedef logic [ELEM_W-1:0] elem_t;
    // Four entries, row-major, entry 0 (row 0, column 0) in the lowest bits.
    typedef logic [3:0][ELEM_W-1:0] mat_t;

    localparam elem_t PRIME = 30'd1000000007;

    // Barrett constant floor(2^60 / PRIME), fits in 31 bits.
    localparam logic [61:0] BARRETT_MU_FULL = (62'd1 << 60) / 62'd1000000007;
    localparam logic [30:0] BARRETT_MU      = BARRETT_MU_FULL[30:0];

    // Barrett leaves a remainder below three times the prime.
    localparam logic [31:0] PRIME_X3 = 32'd3000000021;

endpackage : mmp2_pkg

`default_nettype wire

/* hdl/modular_matrix_power_2x2_unit.sv */
// Top level of the 2x2 modular matrix power unit: one sequencer around a single
// shared 32x32 multiplier. Depends on mmp2_pkg for the modulus and matrix type.
`default_nettype none

// This unit raises a 2x2 matrix of residues to a 63-bit power modulo the prime
// 1000000007 with right-to-left square-and-multiply, and returns one result
// matrix for every request. Input entries at or above the prime are reduced
// first, and an exponent of zero gives the identity matrix. All arithmetic runs
// through one 32x32 multiplier that each modular product uses three times (the
// product itself and two Barrett reduction steps), followed by two correction
// subtractions and one modular add into the running entry. A matrix product
// forms its eight terms in turn, then writes the result back. Every exponent
// bit up to the top set bit has its own step that picks the next product, every
// set bit costs one product, and every bit below the top set bit costs one
// squaring. The unit takes no new request while it works, but a finished result
// sits in its own output register, so the next request is accepted while that
// result waits to be taken.
module modular_matrix_power_2x2_unit
    import mmp2_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // From bit 0: m00[29:0], m01[59:30], m10[89:60], m11[119:90],
    // power[182:120], zero pad[183].
    input  wire logic [183:0] s_tdata,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // From bit 0: r00[29:0], r01[59:30], r10[89:60], r11[119:90].
    output logic [119:0]      m_tdata
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_BIT  = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_M2   = 4'd3;
    localparam logic [3:0] ST_M3   = 4'd4;
    localparam logic [3:0] ST_R1   = 4'd5;
    localparam logic [3:0] ST_R2   = 4'd6;
    localparam logic [3:0] ST_R3   = 4'd7;
    localparam logic [3:0] ST_ACC  = 4'd8;
    localparam logic [3:0] ST_WB   = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    // Which matrix product is being formed.
    localparam logic MODE_SQR = 1'b0;   // base = base * base
    localparam logic MODE_MUL = 1'b1;   // acc  = acc * base

    logic [3:0]         state_reg, state_next;
    logic               mode_reg, mode_next;
    logic [2:0]         term_reg, term_next;
    logic [POWER_W-1:0] pow_reg, pow_next;
    mat_t               base_reg, base_next;
    mat_t               acc_reg, acc_next;
    mat_t               new_reg, new_next;
    elem_t              part_reg, part_next;
    logic [59:0]        prod_reg, prod_next;
    logic [61:0]        mul_reg, mul_next;
    logic [31:0]        r_reg, r_next;
    mat_t               out_reg, out_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [31:0]        mul_a, mul_b;
    logic [61:0]        mul_out;
    logic [1:0]         idx_x, idx_y;
    elem_t              x_op, y_op;
    logic [30:0]        acc_sum;
    elem_t              acc_sum_red;
    logic               s_accept;

    // Entries are below twice the prime, so one conditional subtract reduces them.
    function automatic elem_t reduce_in(input elem_t val);
        elem_t res;
        res = (val >= PRIME) ? val - PRIME : val;
        return res;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // Term counter: bit 2 is the row i, bit 1 the column k, bit 0 the inner index j.
    assign idx_x = {term_reg[2], term_reg[0]};
    assign idx_y = {term_reg[0], term_reg[1]};
    assign x_op  = (mode_reg == MODE_MUL) ? acc_reg[idx_x] : base_reg[idx_x];
    assign y_op  = base_reg[idx_y];

    // The shared multiplier and its operand selection.
    always_comb begin
        case (state_reg)
            ST_M1: begin
                mul_a = {2'b00, x_op};
                mul_b = {2'b00, y_op};
            end
            ST_M2: begin
                mul_a = {1'b0, prod_reg[59:29]};
                mul_b = {1'b0, BARRETT_MU};
            end
            ST_M3: begin
                mul_a = {1'b0, mul_reg[61:31]};
                mul_b = {2'b00, PRIME};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // Every operand pair used here has a product below 2^62.
    assign mul_out = 62'(64'(mul_a) * 64'(mul_b));

    // Modular add of the reduced term into the entry being built.
    assign acc_sum     = (term_reg[0] ? {1'b0, part_reg} : 31'd0) + {1'b0, r_reg[29:0]};
    assign acc_sum_red = (acc_sum >= {1'b0, PRIME}) ? 30'(acc_sum - {1'b0, PRIME})
                                                    : acc_sum[29:0];

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        term_next     = term_reg;
        pow_next      = pow_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        new_next      = new_reg;
        part_next     = part_reg;
        prod_next     = prod_reg;
        mul_next      = mul_reg;
        r_next        = r_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    base_next[0] = reduce_in(s_tdata[29:0]);
                    base_next[1] = reduce_in(s_tdata[59:30]);
                    base_next[2] = reduce_in(s_tdata[89:60]);
                    base_next[3] = reduce_in(s_tdata[119:90]);
                    acc_next[0]  = 30'd1;
                    acc_next[1]  = 30'd0;
                    acc_next[2]  = 30'd0;
                    acc_next[3]  = 30'd1;
                    pow_next     = s_tdata[182:120];
                    state_next   = (s_tdata[182:120] == '0) ? ST_DONE : ST_BIT;
                end
            end
            ST_BIT: begin
                mode_next  = pow_reg[0] ? MODE_MUL : MODE_SQR;
                term_next  = 3'd0;
                state_next = ST_M1;
            end
            ST_M1: begin
                prod_next  = mul_out[59:0];
                state_next = ST_M2;
            end
            ST_M2: begin
                mul_next   = mul_out;
                state_next = ST_M3;
            end
            ST_M3: begin
                mul_next   = mul_out;
                state_next = ST_R1;
            end
            ST_R1: begin
                r_next     = prod_reg[31:0] - mul_reg[31:0];
                state_next = ST_R2;
            end
            ST_R2: begin
                r_next     = (r_reg >= {2'b00, PRIME}) ? r_reg - {2'b00, PRIME} : r_reg;
                state_next = ST_R3;
            end
            ST_R3: begin
                r_next     = (r_reg >= {2'b00, PRIME}) ? r_reg - {2'b00, PRIME} : r_reg;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (term_reg[0]) begin
                    new_next[term_reg[2:1]] = acc_sum_red;
                end else begin
                    part_next = acc_sum_red;
                end
                term_next  = term_reg + 3'd1;
                state_next = (term_reg == 3'd7) ? ST_WB : ST_M1;
            end
            ST_WB: begin
                if (mode_reg == MODE_MUL) begin
                    acc_next = new_reg;
                    // After the top set bit the final squaring is never used.
                    if (pow_reg[POWER_W-1:1] == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        mode_next  = MODE_SQR;
                        term_next  = 3'd0;
                        state_next = ST_M1;
                    end
                end else begin
                    base_next  = new_reg;
                    pow_next   = pow_reg >> 1;
                    state_next = (pow_reg[POWER_W-1:1] == '0) ? ST_DONE : ST_BIT;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = acc_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        term_reg <= term_next;
        pow_reg  <= pow_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        new_reg  <= new_next;
        part_reg <= part_next;
        prod_reg <= prod_next;
        mul_reg  <= mul_next;
        r_reg    <= r_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    // Barrett estimate is never more than two primes short.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_R2) |-> (r_reg < PRIME_X3))
        else $error("Barrett remainder out of range");

    // After both corrections the term is a residue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) |-> (r_reg < {2'b00, PRIME}))
        else $error("reduced term not below the prime");

    // The accumulator and the new product hold residues at every write-back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) |-> (acc_reg[0] < PRIME && acc_reg[1] < PRIME &&
                                  acc_reg[2] < PRIME && acc_reg[3] < PRIME &&
                                  new_reg[0] < PRIME && new_reg[1] < PRIME &&
                                  new_reg[2] < PRIME && new_reg[3] < PRIME))
        else $error("matrix entry not below the prime");

    // An accepted request blocks further requests until the result is loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("second request taken while busy");

    // A new result is only loaded when the output register is free or draining.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result overwritten while waiting");
`endif

endmodule : modular_matrix_power_2x2_unit

`default_nettype wire

/* tb/modular_matrix_power_2x2_unit_tb.sv */
// Self-checking testbench for modular_matrix_power_2x2_unit: matrix power requests
// against a behavioral square-and-multiply predictor, with random idling on both sides.
// Depends on mmp2_pkg for the modulus, the element width and the matrix type.
`timescale 1ns / 100ps

module modular_matrix_power_2x2_unit_tb;
    import mmp2_pkg::*;

    // Total request count that the random phases fill up to.
    localparam int ITEM_TARGET = 580;
    // Exponents wider than this many bits count as full-width (slow) requests.
    localparam int NARROW_BITS = 12;

    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};
    localparam elem_t ELEM_ONES = {ELEM_W{1'b1}};
    localparam logic [63:0] PRIME_WIDE = 64'(PRIME);

    // Entries of the predictor matrices are held in 64 bits so that one product of
    // two residues and the running sum never overflow.
    typedef logic [3:0][63:0] wide_mat_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    // From bit 0: m00[29:0], m01[59:30], m10[89:60], m11[119:90],
    // power[182:120], zero pad[183].
    logic [183:0] s_tdata  = '0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    // From bit 0: r00[29:0], r01[59:30], r10[89:60], r11[119:90].
    wire  [119:0] m_tdata;

    // Result matrices still owed by the unit, oldest first.
    mat_t expected_powers[$];

    int  mismatches    = 0;
    int  results_seen  = 0;
    int  requests_sent = 0;
    int  wide_requests = 0;
    int  stall_left    = 0;
    // While set, neither side inserts idle cycles.
    bit  idle_off      = 1'b0;

    modular_matrix_power_2x2_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // One 2x2 product; every term is added into its entry and the sum reduced.
    function automatic wide_mat_t mat_product_mod(wide_mat_t x, wide_mat_t y);
        wide_mat_t r;
        r = '0;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                for (int k = 0; k < 2; k++) begin
                    r[2*i+k] = (r[2*i+k] + x[2*i+j] * y[2*j+k]) % PRIME_WIDE;
                end
            end
        end
        return r;
    endfunction

    // Right-to-left square-and-multiply. Squarings past the top set bit are
    // harmless, so the loop simply runs over every exponent bit.
    function automatic mat_t matrix_power_mod(mat_t base, logic [POWER_W-1:0] exponent);
        wide_mat_t running;
        wide_mat_t acc;
        mat_t      res;
        for (int e = 0; e < 4; e++) begin
            running[e] = 64'(base[e]) % PRIME_WIDE;
        end
        acc    = '0;
        acc[0] = 64'd1;
        acc[3] = 64'd1;
        for (int b = 0; b < POWER_W; b++) begin
            if (exponent[b]) begin
                acc = mat_product_mod(acc, running);
            end
            running = mat_product_mod(running, running);
        end
        for (int e = 0; e < 4; e++) begin
            res[e] = acc[e][ELEM_W-1:0];
        end
        return res;
    endfunction

    function automatic mat_t make_mat(elem_t a00, elem_t a01, elem_t a10, elem_t a11);
        return {a11, a10, a01, a00};
    endfunction

    function automatic int draw_idle();
        return idle_off ? 0 : $urandom_range(0, 6);
    endfunction

    // Entries lean on the edges around the prime; the rest are uniform over
    // all 30 bits, which also lands above the prime now and then.
    function automatic elem_t draw_entry();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PRIME - 30'd1;
            2: return PRIME;
            3: return ELEM_ONES;
            default: return elem_t'($urandom());
        endcase
    endfunction

    function automatic mat_t draw_matrix();
        return make_mat(draw_entry(), draw_entry(), draw_entry(), draw_entry());
    endfunction

    // Most exponents are narrow to keep the run short; about one in 25 uses
    // all 63 bits so that every exponent bit toggles.
    function automatic logic [POWER_W-1:0] draw_exponent();
        logic [63:0]        raw;
        logic [POWER_W-1:0] mask;
        raw = {$urandom(), $urandom()};
        if ($urandom_range(0, 24) == 0) begin
            return raw[POWER_W-1:0];
        end
        mask = (63'd1 << $urandom_range(0, NARROW_BITS)) - 63'd1;
        return raw[POWER_W-1:0] & mask;
    endfunction

    // Sends one request. Called at a rising edge; returns at the edge where the
    // request is accepted, with s_tvalid still high so that a following request
    // can go out back to back without a second assignment in the same step.
    task automatic send_request(input mat_t base, input logic [POWER_W-1:0] exponent);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, exponent, base};
        do @(posedge aclk); while (!s_tready);
        expected_powers.insert(expected_powers.size(), matrix_power_mod(base, exponent));
        requests_sent++;
        if (exponent[POWER_W-1:NARROW_BITS] != '0) begin
            wide_requests++;
        end
    endtask

    // Holds off the sender until every outstanding result has been taken.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_powers.size() != 0) @(posedge aclk);
    endtask

    task automatic test_zero_exponent();
        send_request(make_mat('0, '0, '0, '0), '0);
        send_request(make_mat(ELEM_ONES, ELEM_ONES, ELEM_ONES, ELEM_ONES), '0);
        send_request(draw_matrix(), '0);
    endtask

    // Entries at or above the prime must be reduced before use.
    task automatic test_entry_above_prime();
        send_request(make_mat(PRIME, PRIME, PRIME, PRIME), 63'd1);
        send_request(make_mat(ELEM_ONES, PRIME + 30'd1, PRIME - 30'd1, ELEM_ONES), 63'd1);
        send_request(make_mat(ELEM_ONES, PRIME + 30'd1, PRIME - 30'd1, ELEM_ONES), 63'd2);
        send_request(make_mat(ELEM_ONES, ELEM_ONES, ELEM_ONES, ELEM_ONES), 63'd3);
        send_request(make_mat(PRIME - 30'd1, '0, '0, PRIME - 30'd1), 63'd5);
    endtask

    task automatic test_exponent_extremes();
        mat_t fib;
        fib = make_mat(30'd1, 30'd1, 30'd1, '0);
        send_request(fib, 63'd90);
        send_request(fib, POWER_MAX);
        send_request(draw_matrix(), POWER_MAX);
        send_request(fib, 63'd1 << (POWER_W - 1));
        send_request(make_mat(PRIME - 30'd1, PRIME - 30'd1, PRIME - 30'd1, PRIME - 30'd1),
                     (63'd1 << (POWER_W - 1)) | 63'd1);
        send_request(make_mat(30'd1, '0, '0, 30'd1), POWER_MAX);
        send_request(make_mat('0, '0, '0, '0), 63'd1);
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++) begin
            send_request(draw_matrix(), draw_exponent());
        end
    endtask

    // Let the pipeline empty completely, then push a burst with no idling on
    // either side, so each request after the first meets a result still waiting to be taken.
    task automatic test_drain_then_burst(input int count);
        wait_for_drain();
        idle_off = 1'b1;
        test_random_mix(count);
        idle_off = 1'b0;
        wait_for_drain();
    endtask

    // Result side: takes every result at the edge where it is accepted, checks
    // it against the oldest expectation and then draws a fresh stall.
    always @(posedge aclk) begin
        mat_t got;
        mat_t want;
        got = m_tdata;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            results_seen++;
            if (expected_powers.size() == 0) begin
                $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_powers.pop_front();
                for (int e = 0; e < 4; e++) begin
                    if (got[e] !== want[e]) begin
                        $display("%0t: r%0d%0d expected %0d, got %0d",
                                 $time, e / 2, e % 2, want[e], got[e]);
                        mismatches++;
                    end
                end
            end
            stall_left = draw_idle();
        end else if (stall_left > 0) begin
            stall_left--;
        end
        m_tready <= (stall_left == 0);
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_zero_exponent();
        test_entry_above_prime();
        test_exponent_extremes();
        test_random_mix(250);
        test_drain_then_burst(80);
        test_random_mix(ITEM_TARGET - requests_sent);

        // All requests are in; collect what is still owed, then watch a little
        // longer for anything unexpected.
        wait_for_drain();
        repeat (100) @(posedge aclk);

        $display("Sent %0d power requests (%0d with wide exponents), checked %0d results.",
                 requests_sent, wide_requests, results_seen);
        $display("Covered zero and full-width exponents, entries at and above the prime,");
        $display("back-to-back bursts and random stalls on both sides.");
        if (mismatches == 0 && expected_powers.size() == 0) begin
            $display("[modular_matrix_power_2x2_unit] OK");
        end else begin
            $display("[modular_matrix_power_2x2_unit] ERROR");
        end
        $finish;
    end

    // Generous ceiling: several times the run with every request at full width.
    initial begin
        #400_000_000;
        $display("Timeout with %0d results outstanding.", expected_powers.size());
        $display("[modular_matrix_power_2x2_unit] ERROR");
        $finish;
    end

endmodule
